@@ hdl/abv_pkg.sv @@
// Shared constants and types for the angle_between_vectors block.
// Holds CORDIC angle table and fixed widths; used by all modules in hdl/.
package abv_pkg;

  localparam int NORM_W  = 25;   // signed normalized component, |v| < 2^24
  localparam int PROD_W  = 50;   // exact dot / cross width
  localparam int CW      = 56;   // CORDIC datapath width (x16 headroom, growth)
  localparam int ZW      = 26;   // angle accumulator width (signed)
  localparam int STEPS   = 20;
  localparam logic signed [ZW-1:0] ANG_90  = 26'sd5901232;
  localparam logic signed [ZW-1:0] ANG_180 = 26'sd11802463;

  function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    begin
      case (i)
        5'd0:  r = 26'sd2950616;
        5'd1:  r = 26'sd1741850;
        5'd2:  r = 26'sd920346;
        5'd3:  r = 26'sd467182;
        5'd4:  r = 26'sd234498;
        5'd5:  r = 26'sd117363;
        5'd6:  r = 26'sd58696;
        5'd7:  r = 26'sd29350;
        5'd8:  r = 26'sd14675;
        5'd9:  r = 26'sd7338;
        5'd10: r = 26'sd3669;
        5'd11: r = 26'sd1834;
        5'd12: r = 26'sd917;
        5'd13: r = 26'sd459;
        5'd14: r = 26'sd229;
        5'd15: r = 26'sd115;
        5'd16: r = 26'sd57;
        5'd17: r = 26'sd29;
        5'd18: r = 26'sd14;
        5'd19: r = 26'sd7;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  typedef struct packed {
    logic                   valid;
    logic                   zero;   // a zero vector: answer is 90-degree code
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic signed [ZW-1:0]   z;
  } abv_cell_t;

endpackage

@@ hdl/angle_between_vectors.sv @@
// angle_between_vectors: angle between two vectors with a common origin.
// Stages in order: subtract, normalize, multiply, product sum, setup, 20 CORDIC
// cells, output register; throughput one request per cycle while the output
// is not stalled, since every stage takes a new request whenever the whole
// pipeline advances, and the whole pipeline advances as one.
// Reset (rst, synchronous, active high) drops all requests in flight.
module angle_between_vectors import abv_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] origin_x,
  input  logic signed [COORD_WIDTH-1:0] origin_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   angle_deg
);
  localparam int DW = COORD_WIDTH + 1;
  // Fraction bits cancel in the angle; keep the parameter visible only as a check.
  localparam int FB_CHECK = FRAC_BITS;

  // The whole pipeline advances when the output register is free or being taken.
  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1: difference vectors.
  logic                 s1_v;
  logic signed [DW-1:0] ax, ay, bx, by;
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= in_valid;
    if (adv) begin
      ax <= DW'(first_x)  - DW'(origin_x);
      ay <= DW'(first_y)  - DW'(origin_y);
      bx <= DW'(second_x) - DW'(origin_x);
      by <= DW'(second_y) - DW'(origin_y);
    end
  end

  // Stage 2: normalize both vectors.
  logic signed [NORM_W-1:0] nax, nay, nbx, nby;
  logic za, zb;
  abv_norm #(.DW(DW)) u_norm_a (.vx(ax), .vy(ay), .nx(nax), .ny(nay), .zero(za));
  abv_norm #(.DW(DW)) u_norm_b (.vx(bx), .vy(by), .nx(nbx), .ny(nby), .zero(zb));

  logic s2_v, s2_z;
  logic signed [NORM_W-1:0] rax, ray, rbx, rby;
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= s1_v;
    if (adv) begin
      s2_z <= za || zb;
      rax <= nax; ray <= nay; rbx <= nbx; rby <= nby;
    end
  end

  // Stage 3: four products, one multiplier each, registered.
  logic s3_v, s3_z;
  logic signed [PROD_W-1:0] pxx, pyy, pxy, pyx;
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (adv) s3_v <= s2_v;
    if (adv) begin
      s3_z <= s2_z;
      pxx <= PROD_W'(rax * rbx);
      pyy <= PROD_W'(ray * rby);
      pxy <= PROD_W'(rax * rby);
      pyx <= PROD_W'(ray * rbx);
    end
  end

  // Stage 4: dot and absolute cross.
  logic s4_v, s4_z;
  logic signed [PROD_W:0] dot, crs;
  logic signed [PROD_W:0] crs_d;
  assign crs_d = (PROD_W+1)'(pxy) - (PROD_W+1)'(pyx);
  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (adv) s4_v <= s3_v;
    if (adv) begin
      s4_z <= s3_z;
      dot <= (PROD_W+1)'(pxx) + (PROD_W+1)'(pyy);
      crs <= crs_d[PROD_W] ? -crs_d : crs_d;
    end
  end

  // Stage 5: pre-rotate into the right half plane, scale by 16, seed the chain.
  abv_cell_t chain [0:STEPS];
  abv_cell_t seed;
  always_comb begin
    seed.valid = s4_v;
    seed.zero  = s4_z;
    if (dot < 0) begin
      seed.x = CW'(crs) <<< 4;
      seed.y = (-CW'(dot)) <<< 4;
      seed.z = ANG_90;
    end else begin
      seed.x = CW'(dot) <<< 4;
      seed.y = CW'(crs) <<< 4;
      seed.z = '0;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) chain[0].valid <= 1'b0;
    else if (adv) chain[0].valid <= seed.valid;
    if (adv) begin
      chain[0].zero <= seed.zero;
      chain[0].x <= seed.x;
      chain[0].y <= seed.y;
      chain[0].z <= seed.z;
    end
  end

  // Row of CORDIC cells, each with its own fixed shift.
  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    abv_cell #(.SHIFT(g)) u_cell (
      .clk (clk), .rst (rst), .en (adv), .din (chain[g]), .dout (chain[g+1])
    );
  end

  // Clamp, round, and hold in the output register.
  abv_cell_t last;
  logic signed [ZW-1:0] zc;
  logic signed [ZW-1:0] zr;
  always_comb begin
    last = chain[STEPS];
    if (last.zero) zc = ANG_90;
    else if (last.z < 0) zc = '0;
    else if (last.z > ANG_180) zc = ANG_180;
    else zc = last.z;
    zr = zc + ZW'(128);
  end
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= last.valid;
    if (adv) angle_deg <= zr[23:8];
  end

  // Checks.
  a_fb_range: assert property (@(posedge clk) FB_CHECK >= 0)
    else $error("FRAC_BITS out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(angle_deg))
    else $error("result changed while stalled");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> angle_deg <= 16'd46104)
    else $error("angle beyond 180 code");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");
endmodule

@@ hdl/abv_norm.sv @@
// Normalization cell: rescale one difference vector so that its larger
// magnitude lies in [2^23, 2^24). Depends on abv_pkg. Combinational.
module abv_norm import abv_pkg::*; #(
  parameter int DW = 25
) (
  input  logic signed [DW-1:0]     vx,
  input  logic signed [DW-1:0]     vy,
  output logic signed [NORM_W-1:0] nx,
  output logic signed [NORM_W-1:0] ny,
  output logic                     zero
);
  localparam int MW = DW + 24;
  localparam int LZW = $clog2(MW + 1);

  logic [DW-1:0] ax, ay, m;
  logic signed [MW-1:0] wx, wy;
  logic [LZW-1:0] top;
  logic signed [MW-1:0] sx, sy, tx, ty;
  logic [MW-1:0] mm;

  always_comb begin
    ax = vx[DW-1] ? DW'(-vx) : vx;
    ay = vy[DW-1] ? DW'(-vy) : vy;
    m  = (ax > ay) ? ax : ay;
    zero = (m == '0);
    top = '0;
    for (int i = 0; i < DW; i++) begin
      if (m[i]) top = LZW'(i);
    end
    wx = MW'(vx);
    wy = MW'(vy);
    mm = MW'(0);
    // left align so top bit sits at 23 (exact when shifting up)
    if (top <= LZW'(23)) begin
      sx = wx <<< (LZW'(23) - top);
      sy = wy <<< (LZW'(23) - top);
      tx = sx;
      ty = sy;
    end else begin
      sx = wx >>> (top - LZW'(23));
      sy = wy >>> (top - LZW'(23));
      // floor shift may push a negative component to exactly -2^24
      if (sx[MW-1] && (-sx) >= (MW'(1) <<< 24)) mm = '1;
      if (sy[MW-1] && (-sy) >= (MW'(1) <<< 24)) mm = '1;
      tx = mm[0] ? (sx >>> 1) : sx;
      ty = mm[0] ? (sy >>> 1) : sy;
    end
    nx = NORM_W'(tx);
    ny = NORM_W'(ty);
  end
endmodule

@@ hdl/abv_cell.sv @@
// One CORDIC vectoring cell: a fixed micro-rotation and a pipeline register.
// Depends on abv_pkg. Instantiated STEPS times by the top level.
module abv_cell import abv_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  abv_cell_t din,
  output abv_cell_t dout
);
  abv_cell_t nxt;
  logic signed [CW-1:0] xs, ys;

  always_comb begin
    xs = din.x >>> SHIFT;
    ys = din.y >>> SHIFT;
    nxt = din;
    if (din.y < 0) begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - atan_val(5'(SHIFT));
    end else begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + atan_val(5'(SHIFT));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.zero <= nxt.zero;
      dout.x    <= nxt.x;
      dout.y    <= nxt.y;
      dout.z    <= nxt.z;
    end
  end
endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for angle_between_vectors: random and directed vector requests.
// Depends on hdl/abv_pkg.sv and hdl/angle_between_vectors.sv; predicts each angle in place.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CWID = 24;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam longint ANG_RIGHT = 5901232;
  localparam longint ANG_STRAIGHT = 11802463;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CWID-1:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
  logic signed [CWID-1:0] origin_x = '0, origin_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] angle_deg;

  logic [15:0] angle_queue[$];
  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  angle_between_vectors #(.COORD_WIDTH(CWID), .FRAC_BITS(8)) i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y),
    .origin_x(origin_x), .origin_y(origin_y),
    .out_valid(out_valid), .out_ready(out_ready), .angle_deg(angle_deg)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bail out if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("FAIL angle_between_vectors");
      $finish;
    end
  end

  // Floor shift for signed values.
  function automatic longint floor_shift(longint v, int k);
    return v >>> k;
  endfunction

  // Bring the larger component magnitude into [2^23, 2^24); return 0 for a zero vector.
  function automatic bit fit_vector(inout longint vx, inout longint vy);
    longint m;
    m = (vx < 0 ? -vx : vx);
    if ((vy < 0 ? -vy : vy) > m) m = (vy < 0 ? -vy : vy);
    if (m == 0) return 1'b0;
    while (m < (64'sd1 <<< 23)) begin
      vx = vx * 2; vy = vy * 2; m = m * 2;
    end
    while (m >= (64'sd1 <<< 24)) begin
      vx = floor_shift(vx, 1); vy = floor_shift(vy, 1);
      m = (vx < 0 ? -vx : vx);
      if ((vy < 0 ? -vy : vy) > m) m = (vy < 0 ? -vy : vy);
    end
    return 1'b1;
  endfunction

  function automatic longint arctan_step(int i);
    longint tab[20] = '{2950616, 1741850, 920346, 467182, 234498, 117363, 58696, 29350,
                        14675, 7338, 3669, 1834, 917, 459, 229, 115, 57, 29, 14, 7};
    return tab[i];
  endfunction

  // Predict the angle code for one request.
  function automatic logic [15:0] predict_angle(
      logic signed [CWID-1:0] fx, logic signed [CWID-1:0] fy,
      logic signed [CWID-1:0] sx, logic signed [CWID-1:0] sy,
      logic signed [CWID-1:0] ox, logic signed [CWID-1:0] oy);
    longint ax, ay, bx, by, px, py, z, t, xs, ys;
    bit a_ok, b_ok;
    ax = longint'(fx) - longint'(ox);
    ay = longint'(fy) - longint'(oy);
    bx = longint'(sx) - longint'(ox);
    by = longint'(sy) - longint'(oy);
    a_ok = fit_vector(ax, ay);
    b_ok = a_ok ? fit_vector(bx, by) : 1'b0;
    if (!a_ok || !b_ok) begin
      z = ANG_RIGHT;
    end else begin
      px = ax * bx + ay * by;
      py = ax * by - ay * bx;
      if (py < 0) py = -py;
      z = 0;
      // Obtuse: rotate by 90 degrees first so CORDIC works in the right half plane.
      if (px < 0) begin
        t = px; px = py; py = -t; z = ANG_RIGHT;
      end
      px = px * 16; py = py * 16;
      for (int i = 0; i < 20; i++) begin
        xs = floor_shift(px, i);
        ys = floor_shift(py, i);
        if (py < 0) begin
          px = px - ys; py = py + xs; z = z - arctan_step(i);
        end else begin
          px = px + ys; py = py - xs; z = z + arctan_step(i);
        end
      end
      if (z < 0) z = 0;
      if (z > ANG_STRAIGHT) z = ANG_STRAIGHT;
    end
    return 16'((z + 128) >>> 8);
  endfunction

  // Send one request, holding it until accepted; record its expected angle.
  // Valid stays high into the next request unless the sender idles.
  task automatic send_request(input logic signed [CWID-1:0] fx, fy, sx, sy, ox, oy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    first_x <= fx; first_y <= fy; second_x <= sx; second_y <= sy;
    origin_x <= ox; origin_y <= oy;
    angle_queue.push_back(predict_angle(fx, fy, sx, sy, ox, oy));
    do @(posedge clk); while (!in_ready);
  endtask

  // Randomly stall the result side.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst && out_valid && out_ready) begin
      if (angle_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result angle_deg=%0d", angle_deg);
      end else begin
        want = angle_queue.pop_front();
        if (want !== angle_deg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("angle mismatch: expected %0d got %0d", want, angle_deg);
        end
      end
    end
  end

  function automatic logic signed [CWID-1:0] rand_coord();
    case ($urandom_range(3))
      0: return CWID'($urandom);
      1: return CWID'($signed($urandom_range(512)) - 256);
      2: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
      default: return CWID'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  // Extremes, zero vectors, parallel, opposite and perpendicular vectors.
  task automatic test_directed();
    send_request(0, 0, 0, 0, 0, 0);
    send_request(5, 7, 5, 7, 5, 7);
    send_request(256, 0, 0, 0, 0, 0);
    send_request(256, 0, 512, 0, 0, 0);
    send_request(256, 0, -256, 0, 0, 0);
    send_request(256, 0, 0, 256, 0, 0);
    send_request(0, 256, 256, 0, 0, 0);
    send_request(256, 256, -256, 0, 0, 0);
    send_request(24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh800000, 0, 0);
    send_request(24'sh7fffff, 24'sh800000, 24'sh800000, 24'sh7fffff,
                 24'sh800000, 24'sh7fffff);
    send_request(24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh7fffff,
                 24'sh7fffff, 24'sh800000);
    send_request(1, 0, 0, -1, 0, 0);
    send_request(1, 1, -1, -1, 0, 0);
    send_request(3, 0, 3, 1, 0, 0);
    send_request(24'sh7fffff, 0, 24'sh7fffff, 1, 0, 0);
    send_request(-1, 0, -1, 0, 0, 0);
    send_request(-24'sd100, 24'sd1, -24'sd100, -24'sd1, 0, 0);
    send_request(24'sh555555, 24'shaaaaaa, 24'shaaaaaa, 24'sh555555, 0, 0);
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++)
      send_request(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord());
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (angle_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle_pct = 30; recv_idle_pct = 67;
    test_random(210);
    send_idle_pct = 67; recv_idle_pct = 30;
    test_random(210);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(210);
    drain_results();
    if (mismatches == 0 && angle_queue.size() == 0)
      $display("PASS angle_between_vectors");
    else
      $display("FAIL angle_between_vectors");
    $finish;
  end
endmodule

@@ sim.f @@
hdl/abv_pkg.sv
hdl/abv_norm.sv
hdl/abv_cell.sv
hdl/angle_between_vectors.sv
sim/tb_top.sv
